FILE: rtl/dspf_pkg.sv
// ----------------------------------------------------------------------------
// dspf_pkg: shared types and constants of the damped spring pair force block
// Stage counts, saturation limit, register indexes and pipeline records.
// ----------------------------------------------------------------------------
package dspf_pkg;

  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 64;
  localparam int UDIV_STEPS  = 17;
  localparam int FRONT_STAGES = 4;
  localparam int POST_STAGES = 10;
  localparam int LATENCY     = FRONT_STAGES + SQRT_STEPS + 1 + DIV_STEPS + POST_STAGES;

  localparam logic [61:0] SAT_MAG = '1;

  typedef enum logic [1:0] {
    REG_STIFFNESS = 2'd0,
    REG_DAMPING   = 2'd1,
    REG_REST      = 2'd2,
    REG_TIME_STEP = 2'd3
  } reg_idx_t;

  // square root pipeline record
  typedef struct packed {
    logic [33:0]             rem;
    logic [31:0]             root;
    logic [63:0]             xs;
    logic signed [49:0]      dot;
    logic [2:0][31:0]        d;
  } sq_t;

  // divider pipeline record
  typedef struct packed {
    logic                    zero;
    logic [31:0]             len;
    logic                    pneg;
    logic [31:0]             rem;
    logic [63:0]             nq;
    logic [2:0]              uneg;
    logic [2:0][31:0]        urem;
    logic [2:0][16:0]        unq;
  } dv_t;

  // axis data carried beside the scalar path
  typedef struct packed {
    logic                    zero;
    logic [2:0]              uneg;
    logic [2:0][16:0]        umag;
  } ax_t;

endpackage

FILE: rtl/damped_spring_pair_force.sv
// ----------------------------------------------------------------------------
// damped_spring_pair_force: damped spring force on the first body of a pair
// Q16.16 separation, length by pipelined square root, axis and damping
// projection by pipelined restoring dividers, saturating scalar products.
// ----------------------------------------------------------------------------
//  channel   signals                                  handshake
//  config    psel penable pwrite paddr pwdata prdata  APB, pready always high
//  input     start busy, 12 position/velocity fields  start & !busy
//  result    done, force_x/y/z, zero_length           one-cycle strobe
//
//  One beat is accepted every cycle; busy is always low.
//  A result leaves through the 32-step square root and the 64-step
//  quotient pipeline, one bit per stage.
//  Synchronous reset clears the valid line and loads the configuration registers with their defaults.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module damped_spring_pair_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] first_pos_x,
  input  logic signed [31:0] first_pos_y,
  input  logic signed [31:0] first_pos_z,
  input  logic signed [31:0] second_pos_x,
  input  logic signed [31:0] second_pos_y,
  input  logic signed [31:0] second_pos_z,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic signed [31:0] first_vel_z,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic signed [31:0] second_vel_z,
  output logic               done,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic               zero_length
);
  import dspf_pkg::*;

  logic [30:0] stiffness, damping, rest_len, time_step;
  logic [LATENCY-1:0] vld;

  function automatic logic [31:0] sat_sub(logic [31:0] a, logic [31:0] b);
    logic [32:0] t;
    t = {b[31], b} - {a[31], a};
    if (t[32] != t[31]) begin
      sat_sub = t[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat_sub = t[31:0];
    end
  endfunction

  function automatic sq_t sq_step(sq_t a);
    sq_t r;
    logic [35:0] rm;
    logic [35:0] t;
    r    = a;
    rm   = {a.rem, a.xs[63:62]};
    t    = {2'b00, a.root, 2'b01};
    r.xs = {a.xs[61:0], 2'b00};
    if (rm >= t) begin
      r.rem  = 34'(rm - t);
      r.root = {a.root[30:0], 1'b1};
    end else begin
      r.rem  = rm[33:0];
      r.root = {a.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t a, logic do_u);
    dv_t r;
    logic [32:0] rp;
    logic [32:0] up;
    r  = a;
    rp = {a.rem, a.nq[63]};
    if (rp >= {1'b0, a.len}) begin
      r.rem = 32'(rp - {1'b0, a.len});
      r.nq  = {a.nq[62:0], 1'b1};
    end else begin
      r.rem = rp[31:0];
      r.nq  = {a.nq[62:0], 1'b0};
    end
    if (do_u) begin
      for (int i = 0; i < 3; i++) begin
        up = {a.urem[i], a.unq[i][16]};
        if (up >= {1'b0, a.len}) begin
          r.urem[i] = 32'(up - {1'b0, a.len});
          r.unq[i]  = {a.unq[i][15:0], 1'b1};
        end else begin
          r.urem[i] = up[31:0];
          r.unq[i]  = {a.unq[i][15:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= 31'd65536;
      damping   <= 31'd0;
      rest_len  <= 31'd65536;
      time_step <= 31'd655;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_STIFFNESS: stiffness <= pwdata[30:0];
        REG_DAMPING:   damping   <= pwdata[30:0];
        REG_REST:      rest_len  <= pwdata[30:0];
        REG_TIME_STEP: time_step <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_STIFFNESS: prdata = {1'b0, stiffness};
      REG_DAMPING:   prdata = {1'b0, damping};
      REG_REST:      prdata = {1'b0, rest_len};
      REG_TIME_STEP: prdata = {1'b0, time_step};
    endcase
  end

  // valid line: no stalls, so every beat moves one stage per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start};
    end
  end
  assign done = vld[LATENCY-1];

  // front: separations, products, sums and the square root pipeline
  logic [2:0][31:0] s1_d, s1_w;
  logic [2:0][31:0] s2_d;
  logic [2:0][63:0] s2_pw;
  logic [2:0][62:0] s2_pd;
  logic [2:0][31:0] s3_d;
  logic [2:0][47:0] s3_tr;
  logic [63:0]      s3_sq01;
  logic [62:0]      s3_pd2;
  sq_t              sr [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    s1_d[0] <= sat_sub(first_pos_x, second_pos_x);
    s1_d[1] <= sat_sub(first_pos_y, second_pos_y);
    s1_d[2] <= sat_sub(first_pos_z, second_pos_z);
    s1_w[0] <= sat_sub(first_vel_x, second_vel_x);
    s1_w[1] <= sat_sub(first_vel_y, second_vel_y);
    s1_w[2] <= sat_sub(first_vel_z, second_vel_z);

    s2_d <= s1_d;
    for (int i = 0; i < 3; i++) begin
      s2_pw[i] <= 64'($signed(s1_w[i]) * $signed(s1_d[i]));
      s2_pd[i] <= 63'($signed(s1_d[i]) * $signed(s1_d[i]));
    end

    s3_d    <= s2_d;
    s3_sq01 <= 64'(s2_pd[0]) + 64'(s2_pd[1]);
    s3_pd2  <= s2_pd[2];
    for (int i = 0; i < 3; i++) begin
      s3_tr[i] <= s2_pw[i][63] ? 48'(($signed(s2_pw[i]) + 64'sd65535) >>> 16)
                               : 48'($signed(s2_pw[i]) >>> 16);
    end

    sr[0].rem  <= '0;
    sr[0].root <= '0;
    sr[0].xs   <= s3_sq01 + 64'(s3_pd2);
    sr[0].dot  <= 50'($signed(s3_tr[0])) + 50'($signed(s3_tr[1]))
                + 50'($signed(s3_tr[2]));
    sr[0].d    <= s3_d;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      sr[j+1] <= sq_step(sr[j]);
    end
  end

  // dividers: projection quotient and the three axis quotients
  dv_t dv [DIV_STEPS+1];
  logic [49:0] dot_mag;
  logic [2:0][31:0] d_mag;

  always_comb begin
    dot_mag = sr[SQRT_STEPS].dot[49] ? 50'(-sr[SQRT_STEPS].dot) : 50'(sr[SQRT_STEPS].dot);
    for (int i = 0; i < 3; i++) begin
      d_mag[i] = sr[SQRT_STEPS].d[i][31] ? 32'(-sr[SQRT_STEPS].d[i]) : sr[SQRT_STEPS].d[i];
    end
  end

  always_ff @(posedge clk) begin
    dv[0].zero <= (sr[SQRT_STEPS].root == 32'd0);
    dv[0].len  <= sr[SQRT_STEPS].root;
    dv[0].pneg <= sr[SQRT_STEPS].dot[49];
    dv[0].rem  <= '0;
    dv[0].nq   <= {dot_mag[47:0], 16'h0000};
    for (int i = 0; i < 3; i++) begin
      dv[0].uneg[i] <= sr[SQRT_STEPS].d[i][31];
      dv[0].urem[i] <= {1'b0, d_mag[i][31:1]};
      dv[0].unq[i]  <= {d_mag[i][0], 16'h0000};
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv[k+1] <= dv_step(dv[k], k < UDIV_STEPS);
    end
  end

  // scalar path and force outputs
  ax_t         axp [POST_STAGES-1];
  logic [61:0] m1_pm;
  logic        m1_pneg, m1_tneg;
  logic [31:0] m1_tmag;
  logic [62:0] m2_pk, m2_pcl;
  logic [60:0] m2_pch;
  logic        m2_pneg, m2_tneg;
  logic [46:0] m3_tmag;
  logic [76:0] m3_dsh;
  logic        m3_pneg, m3_tneg;
  logic [63:0] m4_tens, m4_damp;
  logic [63:0] m5_total;
  logic        m6_neg;
  logic [62:0] m6_tm;
  logic [62:0] m7_p0;
  logic [61:0] m7_p1;
  logic        m7_neg;
  logic [61:0] m8_smag;
  logic        m8_neg;
  logic [2:0][47:0] m9_q0, m9_q1;
  logic        m9_neg;

  logic [92:0] dsum;
  logic [61:0] dmag;
  logic [93:0] ssum;
  logic [2:0][78:0] fsum;
  logic [2:0][62:0] fmag;
  logic [2:0][31:0] fval;
  logic [32:0] len_ext, rest_ext;

  always_comb begin
    len_ext  = {1'b0, dv[DIV_STEPS].len};
    rest_ext = {2'b00, rest_len};
    dsum = {m2_pch, 32'h0} + 93'(m2_pcl);
    dmag = (m3_dsh > 77'(SAT_MAG)) ? SAT_MAG : m3_dsh[61:0];
    ssum = {m7_p1, 32'h0} + 94'(m7_p0);
    for (int i = 0; i < 3; i++) begin
      fsum[i] = {m9_q1[i], 31'h0} + 79'(m9_q0[i]);
      fmag[i] = fsum[i][78:16];
      if (m9_neg ^ axp[POST_STAGES-2].uneg[i]) begin
        fval[i] = (fmag[i] >= 63'h8000_0000) ? 32'h8000_0000 : 32'(-fmag[i]);
      end else begin
        fval[i] = (fmag[i] > 63'h7fff_ffff) ? 32'h7fff_ffff : fmag[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    m1_pm   <= (dv[DIV_STEPS].nq > 64'(SAT_MAG)) ? SAT_MAG : dv[DIV_STEPS].nq[61:0];
    m1_pneg <= dv[DIV_STEPS].pneg;
    m1_tneg <= len_ext < rest_ext;
    m1_tmag <= (len_ext < rest_ext) ? 32'(rest_ext - len_ext) : 32'(len_ext - rest_ext);
    axp[0].zero <= dv[DIV_STEPS].zero;
    axp[0].uneg <= dv[DIV_STEPS].uneg;
    axp[0].umag <= dv[DIV_STEPS].unq;
    for (int i = 0; i < POST_STAGES-2; i++) begin
      axp[i+1] <= axp[i];
    end

    m2_pk   <= 63'(stiffness) * 63'(m1_tmag);
    m2_pcl  <= 63'(damping) * 63'(m1_pm[31:0]);
    m2_pch  <= 61'(damping) * 61'(m1_pm[61:32]);
    m2_pneg <= m1_pneg;
    m2_tneg <= m1_tneg;

    m3_tmag <= m2_pk[62:16];
    m3_dsh  <= dsum[92:16];
    m3_pneg <= m2_pneg;
    m3_tneg <= m2_tneg;

    m4_tens <= m3_tneg ? 64'(-64'(m3_tmag)) : 64'(m3_tmag);
    m4_damp <= m3_pneg ? 64'(-64'(dmag)) : 64'(dmag);

    m5_total <= m4_tens + m4_damp;

    m6_neg <= m5_total[63];
    m6_tm  <= m5_total[63] ? 63'(-m5_total) : m5_total[62:0];

    m7_p0  <= 63'(time_step) * 63'(m6_tm[31:0]);
    m7_p1  <= 62'(time_step) * 62'(m6_tm[62:32]);
    m7_neg <= m6_neg;

    m8_smag <= (ssum[93:16] > 78'(SAT_MAG)) ? SAT_MAG : ssum[77:16];
    m8_neg  <= m7_neg;

    for (int i = 0; i < 3; i++) begin
      m9_q0[i] <= 48'(m8_smag[30:0]) * 48'(axp[POST_STAGES-3].umag[i]);
      m9_q1[i] <= 48'(m8_smag[61:31]) * 48'(axp[POST_STAGES-3].umag[i]);
    end
    m9_neg <= m8_neg;

    zero_length <= axp[POST_STAGES-2].zero;
    force_x     <= axp[POST_STAGES-2].zero ? 32'sd0 : $signed(fval[0]);
    force_y     <= axp[POST_STAGES-2].zero ? 32'sd0 : $signed(fval[1]);
    force_z     <= axp[POST_STAGES-2].zero ? 32'sd0 : $signed(fval[2]);
  end

endmodule
